FILE: rtl/core/rarp_pkg.sv
package rarp_pkg;

   localparam int ENTRIES    = 1024;
   localparam int BLOCK_SIZE = 32;
   localparam int BLOCKS     = ENTRIES / BLOCK_SIZE;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int BLK_W  = $clog2(BLOCKS);
   localparam int OFF_W  = $clog2(BLOCK_SIZE);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]              op;
      logic [IDX_W-1:0]        lo_index;
      logic [IDX_W-1:0]        hi_index;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] best;
   } rsp_type;

endpackage

FILE: rtl/core/rarp_if.sv
interface rarp_req_if;
   logic              valid;
   logic              ready;
   rarp_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rarp_rsp_if;
   logic              valid;
   logic              ready;
   rarp_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/range_add_range_predecessor_top.sv
// Range add / range predecessor over a 1-based array of signed 32-bit entries.
// Requests arrive on req_if (valid/ready); each carries op, lo_index, hi_index
// and operand. A load writes one entry, a range add adds operand to every entry
// in lo_index..hi_index, and a query returns on rsp_if the largest entry in the
// range strictly below operand, with found cleared when there is none.
// Loads and adds return nothing. The block takes one request at a time and
// drops ready until that request's work is done.
// A load writes its entry; an add reads and writes back each entry of a
// partly covered block and updates the tag of each wholly covered block; a
// query reads the (clamped) range entry by entry and then presents its
// response, or goes straight to the response for an empty range.
// The single port of the entry memory sets the pace: a query walks one
// entry per cycle, an add reads and writes back each partly covered entry.
// One adder serves all arithmetic on entry values; whole blocks keep a lazy tag in flops.
// The response sits in an output register, so a new request is taken while it
// waits; a query that finishes while the old response is still unread holds
// until the receiver takes it. Reset clears the tags, the sequencer and the
// response valid; entry contents are undefined until loaded.
module range_add_range_predecessor_top (
   input  logic       clock,
   input  logic       reset,
   rarp_req_if.sink   req_if,
   rarp_rsp_if.source rsp_if
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_ADD    = 3'd2;
   localparam logic [2:0] ST_ADD_WR = 3'd3;
   localparam logic [2:0] ST_QRY    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam int               IDX_W   = rarp_pkg::IDX_W;
   localparam int               DATA_W  = rarp_pkg::DATA_W;
   localparam int               ADDR_W  = rarp_pkg::ADDR_W;
   localparam int               BLK_W   = rarp_pkg::BLK_W;
   localparam int               OFF_W   = rarp_pkg::OFF_W;
   localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(rarp_pkg::ENTRIES);
   localparam logic [IDX_W-1:0] SPAN_M1 = IDX_W'(rarp_pkg::BLOCK_SIZE - 1);
   localparam logic [IDX_W-1:0] SPAN    = IDX_W'(rarp_pkg::BLOCK_SIZE);

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [DATA_W-1:0] oper_ff, oper_in;
   logic              issue_ff, issue_in;
   logic              qv_ff, qv_in;
   logic [DATA_W-1:0] qtag_ff, qtag_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rarp_pkg::rsp_type rsp_ff, rsp_in;

   logic [DATA_W-1:0] tag_ff [rarp_pkg::BLOCKS];
   logic              tag_we;
   logic [DATA_W-1:0] mem [rarp_pkg::ENTRIES];
   logic [DATA_W-1:0] mem_rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_raddr;
   logic [DATA_W-1:0] mem_wdata;

   logic [IDX_W-1:0]  cur_m1;
   logic [ADDR_W-1:0] cur_addr;
   logic [BLK_W-1:0]  cur_blk;
   logic [OFF_W-1:0]  cur_off;
   logic [IDX_W-1:0]  blk_end;
   logic              whole_blk;
   logic [DATA_W-1:0] cur_tag;

   logic [DATA_W-1:0] add_a, add_b, sum;
   logic              add_sub;

   rarp_pkg::req_type req;
   logic              req_acc;
   logic [IDX_W-1:0]  lo_c, hi_c;
   logic              rsp_free;
   logic              below, better;

   assign req     = req_if.payload;
   assign req_acc = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   assign cur_m1    = cur_ff - IDX_W'(1);
   assign cur_addr  = cur_m1[ADDR_W-1:0];
   assign cur_blk   = cur_m1[ADDR_W-1:OFF_W];
   assign cur_off   = cur_m1[OFF_W-1:0];
   assign blk_end   = cur_ff + SPAN_M1;
   assign whole_blk = (cur_off == '0) && (blk_end <= hi_ff);
   assign cur_tag   = tag_ff[cur_blk];

   assign lo_c = (req.lo_index == '0) ? IDX_W'(1) : req.lo_index;
   assign hi_c = (req.hi_index > LAST_IX) ? LAST_IX : req.hi_index;

   // The one adder for entry values in the block; each state feeds it what it needs.
   always_comb begin
      add_a   = oper_ff;
      add_b   = cur_tag;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            add_a   = oper_ff;
            add_b   = cur_tag;
            add_sub = 1'b1;
         end
         ST_ADD: begin
            add_a = cur_tag;
            add_b = oper_ff;
         end
         ST_ADD_WR: begin
            add_a = mem_rd_ff;
            add_b = oper_ff;
         end
         ST_QRY: begin
            add_a = mem_rd_ff;
            add_b = qtag_ff;
         end
         default: begin
            add_a   = oper_ff;
            add_b   = cur_tag;
            add_sub = 1'b0;
         end
      endcase
      sum = add_a + (add_sub ? ~add_b : add_b) + DATA_W'(add_sub);
   end

   assign below  = $signed(sum) < $signed(oper_ff);
   assign better = !found_ff || ($signed(best_ff) < $signed(sum));
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      hi_in        = hi_ff;
      oper_in      = oper_ff;
      issue_in     = issue_ff;
      qv_in        = 1'b0;
      qtag_in      = cur_tag;
      found_in     = found_ff;
      best_in      = best_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      tag_we       = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = cur_addr;
      mem_wdata    = sum;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               oper_in  = req.operand;
               hi_in    = hi_c;
               found_in = 1'b0;
               best_in  = '0;
               unique case (req.op)
                  rarp_pkg::OP_LOAD: begin
                     cur_in = req.lo_index;
                     if (req.lo_index != '0 && req.lo_index <= LAST_IX) begin
                        state_in = ST_LOAD;
                     end
                  end
                  rarp_pkg::OP_ADD: begin
                     cur_in = lo_c;
                     if (lo_c <= hi_c) begin
                        state_in = ST_ADD;
                     end
                  end
                  rarp_pkg::OP_QUERY: begin
                     cur_in   = lo_c;
                     issue_in = 1'b1;
                     state_in = (lo_c <= hi_c) ? ST_QRY : ST_DONE;
                  end
                  rarp_pkg::OP_NONE: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_ADD: begin
            if (whole_blk) begin
               tag_we = 1'b1;
               cur_in = cur_ff + SPAN;
               if (blk_end == hi_ff) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            mem_we = 1'b1;
            cur_in = cur_ff + IDX_W'(1);
            state_in = (cur_ff == hi_ff) ? ST_IDLE : ST_ADD;
         end
         ST_QRY: begin
            // Reads are issued in the cycle before the compare stage.
            if (issue_ff) begin
               qv_in = 1'b1;
               if (cur_ff == hi_ff) begin
                  issue_in = 1'b0;
               end else begin
                  cur_in = cur_ff + IDX_W'(1);
               end
            end
            if (qv_ff) begin
               if (below && better) begin
                  found_in = 1'b1;
                  best_in  = sum;
               end
               if (!issue_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = found_ff;
               rsp_in.best  = found_ff ? best_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         qv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         qv_ff        <= qv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      hi_ff   <= hi_in;
      oper_ff <= oper_in;
      qtag_ff <= qtag_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rarp_pkg::BLOCKS; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (tag_we) begin
         tag_ff[cur_blk] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_addr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule

FILE: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W     = rarp_pkg::DATA_W;
   localparam int IDX_W      = rarp_pkg::IDX_W;
   localparam int ENTRIES    = rarp_pkg::ENTRIES;
   localparam int BLOCKS     = rarp_pkg::BLOCKS;
   localparam int BLOCK_SIZE = rarp_pkg::BLOCK_SIZE;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int END_CYCLES     = 300;
   localparam int PHASE_ITEMS    = 105;

   // A low and a high window are loaded and exercised, plus entries 500, 501.
   localparam int LOW_TOP   = 3 * BLOCK_SIZE;
   localparam int HIGH_BASE = ENTRIES - BLOCK_SIZE + 1;

   logic clock;
   logic reset;

   rarp_req_if req_bus();
   rarp_rsp_if rsp_bus();

   range_add_range_predecessor_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Shadow copy of the array: stored words plus one lazy tag per block.
   logic [DATA_W-1:0] stored_words [ENTRIES] = '{default: '0};
   logic [DATA_W-1:0] block_lazy [BLOCKS] = '{default: '0};

   rarp_pkg::req_type queued_requests[$];
   rarp_pkg::rsp_type pending_answers[$];

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   bit  hold_armed    = 0;
   bit  hold_spent    = 0;
   int  hold_left     = 0;
   bit  req_taken     = 0;
   int  idle_run      = 0;
   int  fail_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [DATA_W-1:0] block_tag(int blk);
      return (blk < BLOCKS) ? block_lazy[blk] : '0;
   endfunction

   function automatic logic [DATA_W-1:0] value_at(int idx);
      return stored_words[idx - 1] + block_tag((idx - 1) / BLOCK_SIZE);
   endfunction

   // Applies one accepted request to the shadow array and queues the answer
   // that a query must produce.
   function automatic void track_request(rarp_pkg::req_type r);
      int lo, hi, i, blk, first, last;
      logic [DATA_W-1:0] c, v, best;
      logic hit;
      rarp_pkg::rsp_type answer;
      c  = r.operand;
      lo = int'(r.lo_index);
      hi = int'(r.hi_index);
      case (r.op)
         rarp_pkg::OP_LOAD: begin
            if (lo >= 1 && lo <= ENTRIES)
               stored_words[lo - 1] = c - block_tag((lo - 1) / BLOCK_SIZE);
         end
         rarp_pkg::OP_ADD: begin
            if (lo < 1) lo = 1;
            if (hi > ENTRIES) hi = ENTRIES;
            i = lo;
            while (i <= hi) begin
               blk   = (i - 1) / BLOCK_SIZE;
               first = blk * BLOCK_SIZE + 1;
               last  = first + BLOCK_SIZE - 1;
               if (last > ENTRIES) last = ENTRIES;
               if (i == first && last <= hi && blk < BLOCKS) begin
                  block_lazy[blk] += c;
                  i = last + 1;
               end else begin
                  stored_words[i - 1] += c;
                  i++;
               end
            end
         end
         rarp_pkg::OP_QUERY: begin
            if (lo < 1) lo = 1;
            if (hi > ENTRIES) hi = ENTRIES;
            hit  = 1'b0;
            best = '0;
            for (i = lo; i <= hi; i++) begin
               v = value_at(i);
               if ($signed(v) < $signed(c) && (!hit || $signed(best) < $signed(v))) begin
                  best = v;
                  hit  = 1'b1;
               end
            end
            answer.found = hit;
            answer.best  = hit ? best : '0;
            pending_answers.push_back(answer);
         end
         default: ;
      endcase
   endfunction

   function automatic rarp_pkg::req_type make_request(logic [1:0] op, int lo, int hi,
                                                      logic [DATA_W-1:0] c);
      rarp_pkg::req_type r;
      r.op       = op;
      r.lo_index = IDX_W'(lo);
      r.hi_index = IDX_W'(hi);
      r.operand  = c;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] near_zero(int span);
      return DATA_W'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [DATA_W-1:0] random_bound();
      int k;
      k = $urandom_range(99);
      if (k < 50) return near_zero(600);
      if (k < 60) return 32'h8000_0000 + $urandom_range(3);
      if (k < 70) return 32'h7FFF_FFFF - $urandom_range(3);
      return $urandom();
   endfunction

   function automatic int window_index();
      if ($urandom_range(99) < 75)
         return int'($urandom_range(LOW_TOP, 1));
      return int'($urandom_range(ENTRIES, HIGH_BASE));
   endfunction

   // Ranges stay inside the loaded windows once clamped, or are empty.
   function automatic void random_range(output int lo, output int hi);
      int k;
      k = $urandom_range(99);
      if (k < 10) begin
         lo = int'($urandom_range(ENTRIES, HIGH_BASE));
         hi = int'($urandom_range(2047, ENTRIES));
      end else if (k < 20) begin
         lo = 0;
         hi = int'($urandom_range(LOW_TOP));
      end else if (k < 28) begin
         lo = int'($urandom_range(2047, 2));
         hi = int'($urandom_range(lo - 1));
      end else if (k < 38) begin
         lo = 1 + BLOCK_SIZE * int'($urandom_range(2));
         hi = $urandom_range(1) ? LOW_TOP : lo + BLOCK_SIZE - 1;
      end else if (k < 55) begin
         lo = int'($urandom_range(ENTRIES, HIGH_BASE));
         hi = lo + int'($urandom_range(40)) - 4;
      end else begin
         lo = int'($urandom_range(LOW_TOP, 1));
         hi = lo + int'($urandom_range(48)) - 4;
         if (hi > LOW_TOP) hi = LOW_TOP;
         if (hi < 0) hi = 0;
      end
   endfunction

   function automatic rarp_pkg::req_type random_request();
      int k, lo, hi;
      logic [1:0] op;
      logic [DATA_W-1:0] c;
      k = $urandom_range(99);
      if (k < 28) begin
         op = rarp_pkg::OP_LOAD;
         if ($urandom_range(19) == 0)
            lo = $urandom_range(1) ? 0 : int'($urandom_range(2047, ENTRIES + 1));
         else
            lo = window_index();
         hi = int'($urandom_range(2047));
         c  = $urandom_range(1) ? near_zero(500) : $urandom();
         return make_request(op, lo, hi, c);
      end
      if (k < 33)
         return make_request(rarp_pkg::OP_NONE, int'($urandom_range(2047)),
                             int'($urandom_range(2047)), $urandom());
      op = (k < 58) ? rarp_pkg::OP_ADD : rarp_pkg::OP_QUERY;
      random_range(lo, hi);
      if (op == rarp_pkg::OP_ADD)
         c = ($urandom_range(99) < 60) ? near_zero(20) : $urandom();
      else
         c = random_bound();
      return make_request(op, lo, hi, c);
   endfunction

   task automatic report_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Waits until every queued request is taken and every answer has come back.
   task automatic wait_for_drain();
      while (queued_requests.size() != 0 || req_bus.valid) @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.payload <= queued_requests.pop_front();
            req_bus.valid   <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response receiver, with one long hold-off to back the block up.
   always @(negedge clock) begin
      if (hold_armed && !hold_spent) begin
         hold_spent    <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   // Request monitor feeds the shadow array.
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready)
         track_request(req_bus.payload);
   end

   // Response monitor.
   always @(posedge clock) begin
      rarp_pkg::rsp_type want;
      rarp_pkg::rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (pending_answers.size() == 0) begin
            report_failure($sformatf("unexpected response: found=%0b best=%0d",
                                     got.found, got.best));
         end else begin
            want = pending_answers.pop_front();
            if (want.found !== got.found || want.best !== got.best)
               report_failure($sformatf(
                  "response mismatch: expected found=%0b best=%0d, got found=%0b best=%0d",
                  want.found, want.best, got.found, got.best));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int i, phase;
      rarp_pkg::rsp_type missing;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Both windows are loaded first so that no query or add touches an
      // undefined word; the ends of the array hold the extreme values.
      for (i = 1; i <= ENTRIES; i++) begin
         if (i > LOW_TOP && i < HIGH_BASE)
            continue;
         if (i == 1)
            queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, i,
                                      int'($urandom_range(2047)), 32'h8000_0000));
         else if (i == ENTRIES)
            queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, i,
                                      int'($urandom_range(2047)), 32'h7FFF_FFFF));
         else
            queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, i,
               int'($urandom_range(2047)),
               $urandom_range(1) ? near_zero(500) : $urandom()));
      end

      // Directed cases: extremes, clamped and empty ranges, ignored loads,
      // the unused opcode, equal-to-bound entries and wrapping adds.
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 1, LOW_TOP, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 0, LOW_TOP, 32'h8000_0000));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, HIGH_BASE, 2047,
                                             32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, ENTRIES, ENTRIES,
                                             32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 1, 1, 32'h8000_0001));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 2047, 2047, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 600, 300, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_ADD, 0, LOW_TOP, near_zero(20)));
      queued_requests.push_back(make_request(rarp_pkg::OP_ADD, 5, 70, 32'h8000_0000));
      queued_requests.push_back(make_request(rarp_pkg::OP_ADD, 40, 39, 32'd123));
      queued_requests.push_back(make_request(rarp_pkg::OP_ADD, 33, 64, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_ADD, HIGH_BASE, 2047, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 3, 75, 32'h0));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 30, LOW_TOP, near_zero(300)));
      queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, 0, 2047, $urandom()));
      queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, ENTRIES + 1, 0, $urandom()));
      queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, 2047, 2047, $urandom()));
      queued_requests.push_back(make_request(rarp_pkg::OP_NONE, 2047, 2047, 32'hFFFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_NONE, 0, 0, 32'h0));
      queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, 500, 0, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_LOAD, 501, 0, 32'h8000_0000));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 500, 501, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_ADD, 1, LOW_TOP, 32'hFFFF_FFFF));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, 1, LOW_TOP, 32'h0));
      queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, HIGH_BASE, 2047,
                                             32'h8000_0000));
      wait_for_drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 69; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 69; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         if (phase == 0) begin
            // Short queries while the receiver holds off fill the response
            // register and then stall the request side.
            hold_armed = 1'b1;
            repeat (8) begin
               i = int'($urandom_range(LOW_TOP - 7, 1));
               queued_requests.push_back(make_request(rarp_pkg::OP_QUERY, i,
                                         i + int'($urandom_range(7)), random_bound()));
            end
         end
         repeat (PHASE_ITEMS) queued_requests.push_back(random_request());
         wait_for_drain();
      end

      repeat (END_CYCLES) @(posedge clock);
      while (pending_answers.size() != 0) begin
         missing = pending_answers.pop_front();
         report_failure($sformatf("missing response: expected found=%0b best=%0d",
                                  missing.found, missing.best));
      end
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rarp_pkg.sv
rtl/core/rarp_if.sv
rtl/core/range_add_range_predecessor_top.sv
test/tb_top.sv
